// File: hdl/bgss_pkg.sv
// Shared types and constants of the binary glyph shape statistics block.
package bgss_pkg;

   // Frame size limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Position and dimension widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

   // Register and result field widths
   localparam int CFG_W   = 11;
   localparam int COUNT_W = 21;
   localparam int EXT_W   = 12;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1024);

   // Register indexes
   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // Effective frame geometry handed from the register file
   typedef struct packed {
      logic [WDIM_W-1:0] width;
      logic [HDIM_W-1:0] height;
      logic [COL_W-1:0]  last_col;
      logic [ROW_W-1:0]  last_row;
      logic              restart;
   } geometry_type;

   // Contents of one line buffer column
   typedef struct packed {
      logic prev;
      logic older;
   } lb_bits_type;

   // Line buffer control
   typedef struct packed {
      logic             shift;
      logic             pixel;
      logic [COL_W-1:0] tail;
   } lb_ctrl_type;

   // Neighbors of the pixel directly above the incoming one
   typedef struct packed {
      logic mid;
      logic right;
      logic up;
   } lb_taps_type;

endpackage

// File: hdl/bgss_cell.sv
// One column of the two line buffers: shifts toward the head or loads at the tail.
module bgss_cell import bgss_pkg::*; (
   input  logic        clock,
   input  logic        shift,
   input  logic        tail,
   input  lb_bits_type from_next,
   input  lb_bits_type load,
   output lb_bits_type bits
);

   lb_bits_type bits_ff, bits_in;

   // Take the new column at the tail, else the neighbor's bits
   always_comb begin
      bits_in = bits_ff;
      if (shift) begin
         bits_in = tail ? load : from_next;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
   end

   assign bits = bits_ff;

endmodule

// File: hdl/bgss_line_buffer.sv
// Row of line buffer cells whose tail follows the configured image width.
module bgss_line_buffer import bgss_pkg::*; (
   input  logic        clock,
   input  lb_ctrl_type ctrl,
   output lb_taps_type taps
);

   lb_bits_type cell_q [MAX_WIDTH];
   lb_bits_type load;

   // New column: incoming pixel above, the pixel it replaces one row further up
   assign load.prev  = ctrl.pixel;
   assign load.older = cell_q[0].prev;

   for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
      lb_bits_type from_next;
      logic        tail;

      if (k == MAX_WIDTH - 1) begin : g_end
         assign from_next = '0;
      end else begin : g_mid
         assign from_next = cell_q[k+1];
      end

      assign tail = (ctrl.tail == COL_W'(k));

      bgss_cell u_cell (
         .clock     (clock),
         .shift     (ctrl.shift),
         .tail      (tail),
         .from_next (from_next),
         .load      (load),
         .bits      (cell_q[k])
      );
   end

   // Head of the chain holds the current column, the next cell its right neighbor
   assign taps.mid   = cell_q[0].prev;
   assign taps.right = cell_q[1].prev;
   assign taps.up    = cell_q[0].older;

endmodule

// File: hdl/bgss_csr.sv
// Width and height registers with the effective frame geometry.
module bgss_csr import bgss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output geometry_type          geom
);

   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic              write;
   reg_index_type     index;
   logic [WDIM_W-1:0] width_eff;
   logic [HDIM_W-1:0] height_eff;

   assign pready = 1'b1;
   assign write  = psel && penable && pwrite;
   assign index  = reg_index_type'(paddr[2]);

   // Decode writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (write) begin
         unique case (index)
            REG_WIDTH:  width_in  = pwdata[CFG_W-1:0];
            REG_HEIGHT: height_in = pwdata[CFG_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (index)
         REG_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // Clamp zero to one and oversize to the frame limit
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WDIM_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         width_eff = WDIM_W'(MAX_WIDTH);
      end else begin
         width_eff = WDIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = HDIM_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         height_eff = HDIM_W'(MAX_HEIGHT);
      end else begin
         height_eff = HDIM_W'(height_ff);
      end
   end

   assign geom.width    = width_eff;
   assign geom.height   = height_eff;
   assign geom.last_col = COL_W'(width_eff - WDIM_W'(1));
   assign geom.last_row = ROW_W'(height_eff - HDIM_W'(1));
   assign geom.restart  = write;

endmodule

// File: hdl/binary_glyph_shape_stats.sv
// Top level: binary image area, perimeter and bounding box statistics.
// Pixels enter one per transaction in raster order, row 0 first, column 0 first, and the
// block takes one pixel every clock cycle unless stalled. The two line buffers are a
// chain of one-column cells that shift once per pixel and load at the tail set by the image
// width, so a pixel's upper neighbors sit at the head of the chain when it arrives. The last
// pixel of a frame produces one result transaction (set count, perimeter count, bounding box
// extent sum; an empty frame gives the negated sum of width and height) from an output
// register in the next cycle. While that result is still held by a stalled receiver, only
// the last pixel of the next frame is held back. Any register write abandons the frame in
// progress; write registers only while the block is idle.
module binary_glyph_shape_stats import bgss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Pixel input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_pixel,
   // Result output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [COUNT_W-1:0]       rsp_set_count,
   output logic [COUNT_W-1:0]       rsp_perimeter_count,
   output logic signed [EXT_W-1:0]  rsp_extent_sum,
   // Configuration
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   geometry_type geom;
   lb_ctrl_type  lb_ctrl;
   lb_taps_type  taps;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               left_ff, left_in;
   logic [COUNT_W-1:0] pixels_ff, pixels_in;
   logic [COUNT_W-1:0] perim_ff, perim_in;
   logic               found_ff, found_in;
   logic [COL_W-1:0]   min_col_ff, min_col_in;
   logic [COL_W-1:0]   max_col_ff, max_col_in;
   logic [ROW_W-1:0]   min_row_ff, min_row_in;
   logic [ROW_W-1:0]   max_row_ff, max_row_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] set_count_ff, set_count_in;
   logic [COUNT_W-1:0] perim_count_ff, perim_count_in;
   logic [EXT_W-1:0]   extent_ff, extent_in;

   logic               accept;
   logic               row_end;
   logic               last_row;
   logic               frame_end;
   logic               left, right, up;
   logic               above_edge;
   logic [1:0]         perim_inc;
   logic [COUNT_W-1:0] pixels_sum;
   logic [COUNT_W-1:0] perim_sum;
   logic               found_nxt;
   logic [COL_W-1:0]   min_col_nxt, max_col_nxt;
   logic [ROW_W-1:0]   min_row_nxt, max_row_nxt;

   bgss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .geom    (geom)
   );

   // Hold the last pixel of a frame while the previous result is still stalled
   assign row_end   = (col_ff == geom.last_col);
   assign last_row  = (row_ff == geom.last_row);
   assign frame_end = row_end && last_row;
   assign req_stall = frame_end && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign lb_ctrl.shift = accept;
   assign lb_ctrl.pixel = req_pixel;
   assign lb_ctrl.tail  = geom.last_col;

   bgss_line_buffer u_line_buffer (
      .clock (clock),
      .ctrl  (lb_ctrl),
      .taps  (taps)
   );

   // Decide the pixel above; set pixels of the last row always count
   assign left       = (col_ff != '0) && left_ff;
   assign right      = !row_end && taps.right;
   assign up         = (row_ff > ROW_W'(1)) && taps.up;
   assign above_edge = (row_ff != '0) && taps.mid && !(left && right && up && req_pixel);
   assign perim_inc  = {1'b0, above_edge} + {1'b0, last_row && req_pixel};
   assign pixels_sum = pixels_ff + COUNT_W'(req_pixel);
   assign perim_sum  = perim_ff + COUNT_W'(perim_inc);

   // Grow the bounding box; in raster order the latest set pixel holds the lowest row
   always_comb begin
      found_nxt   = found_ff;
      min_col_nxt = min_col_ff;
      max_col_nxt = max_col_ff;
      min_row_nxt = min_row_ff;
      max_row_nxt = max_row_ff;
      if (req_pixel) begin
         found_nxt   = 1'b1;
         max_row_nxt = row_ff;
         if (!found_ff) begin
            min_col_nxt = col_ff;
            max_col_nxt = col_ff;
            min_row_nxt = row_ff;
         end else begin
            if (col_ff < min_col_ff) begin
               min_col_nxt = col_ff;
            end
            if (col_ff > max_col_ff) begin
               max_col_nxt = col_ff;
            end
         end
      end
   end

   // Advance position and counters, restart on frame end or register write
   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      left_in        = left_ff;
      pixels_in      = pixels_ff;
      perim_in       = perim_ff;
      found_in       = found_ff;
      min_col_in     = min_col_ff;
      max_col_in     = max_col_ff;
      min_row_in     = min_row_ff;
      max_row_in     = max_row_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      set_count_in   = set_count_ff;
      perim_count_in = perim_count_ff;
      extent_in      = extent_ff;
      if (geom.restart) begin
         col_in    = '0;
         row_in    = '0;
         left_in   = 1'b0;
         pixels_in = '0;
         perim_in  = '0;
         found_in  = 1'b0;
      end else if (accept) begin
         pixels_in  = pixels_sum;
         perim_in   = perim_sum;
         found_in   = found_nxt;
         min_col_in = min_col_nxt;
         max_col_in = max_col_nxt;
         min_row_in = min_row_nxt;
         max_row_in = max_row_nxt;
         left_in    = taps.mid;
         col_in     = col_ff + COL_W'(1);
         if (row_end) begin
            col_in  = '0;
            left_in = 1'b0;
            row_in  = row_ff + ROW_W'(1);
         end
         if (frame_end) begin
            row_in         = '0;
            pixels_in      = '0;
            perim_in       = '0;
            found_in       = 1'b0;
            rsp_valid_in   = 1'b1;
            set_count_in   = pixels_sum;
            perim_count_in = perim_sum;
            if (found_nxt) begin
               extent_in = EXT_W'(int'(max_col_nxt) - int'(min_col_nxt)
                                  + int'(max_row_nxt) - int'(min_row_nxt));
            end else begin
               extent_in = EXT_W'(-(int'(geom.width) + int'(geom.height)));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= 1'b0;
         pixels_ff    <= '0;
         perim_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         pixels_ff    <= pixels_in;
         perim_ff     <= perim_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Box corners and result payload
   always_ff @(posedge clock) begin
      min_col_ff     <= min_col_in;
      max_col_ff     <= max_col_in;
      min_row_ff     <= min_row_in;
      max_row_ff     <= max_row_in;
      set_count_ff   <= set_count_in;
      perim_count_ff <= perim_count_in;
      extent_ff      <= extent_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_set_count       = set_count_ff;
   assign rsp_perimeter_count = perim_count_ff;
   assign rsp_extent_sum      = extent_ff;

endmodule

// File: sim/shape_stats_checker.sv
// Scoreboard for the shape statistics block: predicts each frame result and compares it.
module shape_stats_checker import bgss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_pixel,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [COUNT_W-1:0]       rsp_set_count,
   input  logic [COUNT_W-1:0]       rsp_perimeter_count,
   input  logic signed [EXT_W-1:0]  rsp_extent_sum,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   input  logic                     csr_pready,
   output int                       pending_results,
   output int                       mismatch_count
);

   typedef struct packed {
      logic [COUNT_W-1:0]      set_count;
      logic [COUNT_W-1:0]      perimeter_count;
      logic signed [EXT_W-1:0] extent_sum;
   } shape_result_type;

   shape_result_type expected_shapes[$];

   // Shadow registers and frame state
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic             prev_line [MAX_WIDTH];
   logic             older_line [MAX_WIDTH];
   logic             left_pending;
   int unsigned      col_pos;
   int unsigned      row_pos;
   int unsigned      set_total;
   int unsigned      border_total;
   int unsigned      row_set_total;
   int unsigned      box_min_col;
   int unsigned      box_max_col;
   int unsigned      box_min_row;
   int unsigned      box_max_row;
   int               errors_seen = 0;

   // Clamp a size register to the range the block supports
   function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   task automatic restart_frame();
      left_pending  = 1'b0;
      col_pos       = 0;
      row_pos       = 0;
      set_total     = 0;
      border_total  = 0;
      row_set_total = 0;
      box_min_col   = clamp_dim(width_reg, MAX_WIDTH);
      box_max_col   = 0;
      box_min_row   = clamp_dim(height_reg, MAX_HEIGHT);
      box_max_row   = 0;
   endtask

   // Advance the frame by one pixel; queue a result when the frame completes
   task automatic absorb_pixel(input logic p);
      int unsigned      w;
      int unsigned      h;
      int unsigned      x;
      int unsigned      y;
      int unsigned      lft;
      int unsigned      rgt;
      int unsigned      up;
      logic             above;
      int               ext;
      shape_result_type r;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      x = (col_pos >= w) ? w - 1 : col_pos;
      y = (row_pos >= h) ? h - 1 : row_pos;

      if (p) begin
         set_total++;
         row_set_total++;
         if (x < box_min_col) box_min_col = x;
         if (x > box_max_col) box_max_col = x;
         if (y < box_min_row) box_min_row = y;
         if (y > box_max_row) box_max_row = y;
      end

      // decide the pixel directly above now that its lower neighbor is known
      above = prev_line[x];
      if (y >= 1 && above) begin
         lft = (x > 0) ? int'(left_pending) : 0;
         rgt = (x + 1 < w) ? int'(prev_line[x + 1]) : 0;
         up  = (y >= 2) ? int'(older_line[x]) : 0;
         if (lft + rgt + up + int'(p) < 4) border_total++;
      end
      left_pending  = above;
      older_line[x] = above;
      prev_line[x]  = p;

      if (x + 1 < w) begin
         col_pos = x + 1;
      end else if (y + 1 < h) begin
         col_pos       = 0;
         row_pos       = y + 1;
         row_set_total = 0;
         left_pending  = 1'b0;
      end else begin
         // set pixels of the last row always border the clear outside
         border_total += row_set_total;
         ext = (int'(box_max_col) - int'(box_min_col)) + (int'(box_max_row) - int'(box_min_row));
         r.set_count       = COUNT_W'(set_total);
         r.perimeter_count = COUNT_W'(border_total);
         r.extent_sum      = EXT_W'(ext);
         expected_shapes.push_back(r);
         restart_frame();
      end
   endtask

   // Watch the register port, the pixel channel and the result channel
   always @(posedge clock) begin : monitor
      shape_result_type want;
      if (reset) begin
         width_reg  = DIM_RESET;
         height_reg = DIM_RESET;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            prev_line[i]  = 1'b0;
            older_line[i] = 1'b0;
         end
         restart_frame();
         expected_shapes.delete();
      end else begin
         // a write to the width or height register abandons the frame in progress
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == CSR_ADDR_W'({REG_WIDTH, 2'b00})) begin
               width_reg = csr_pwdata[CFG_W-1:0];
               restart_frame();
            end else if (csr_paddr == CSR_ADDR_W'({REG_HEIGHT, 2'b00})) begin
               height_reg = csr_pwdata[CFG_W-1:0];
               restart_frame();
            end
         end

         if (req_valid && !req_stall) absorb_pixel(req_pixel);

         // compare each result transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_shapes.size() == 0) begin
               $error("result transaction with no completed frame waiting");
               errors_seen++;
            end else begin
               want = expected_shapes.pop_front();
               if (rsp_set_count !== want.set_count) begin
                  $error("set_count: expected %0d, got %0d", want.set_count, rsp_set_count);
                  errors_seen++;
               end
               if (rsp_perimeter_count !== want.perimeter_count) begin
                  $error("perimeter_count: expected %0d, got %0d",
                         want.perimeter_count, rsp_perimeter_count);
                  errors_seen++;
               end
               if (rsp_extent_sum !== want.extent_sum) begin
                  $error("extent_sum: expected %0d, got %0d",
                         $signed(want.extent_sum), $signed(rsp_extent_sum));
                  errors_seen++;
               end
            end
         end
      end
      pending_results <= expected_shapes.size();
      mismatch_count  <= errors_seen;
   end

endmodule

// File: sim/testbench.sv
// Top of the shape statistics testbench: clock, reset, pixel stimulus and the verdict.
module testbench;
   import bgss_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 350;
   localparam int RANDOM_FRAMES = 30;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_pixel   = 1'b0;
   logic                    rsp_stall   = 1'b0;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic                    req_stall;
   logic                    rsp_valid;
   logic [COUNT_W-1:0]      rsp_set_count;
   logic [COUNT_W-1:0]      rsp_perimeter_count;
   logic signed [EXT_W-1:0] rsp_extent_sum;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int          pending_results;
   int          mismatch_count;
   int          send_idle_pct = 6;
   int          recv_idle_pct = 69;
   int          hold_asks     = 0;
   int          hold_seen     = 0;
   int          hold_left     = 0;
   int          cycle_count   = 0;
   int unsigned frame_w       = 1;
   int unsigned frame_h       = 1;
   int          items_sent    = 0;
   int          frames_done   = 0;
   int          random_start  = 0;

   binary_glyph_shape_stats uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel           (req_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_set_count       (rsp_set_count),
      .rsp_perimeter_count (rsp_perimeter_count),
      .rsp_extent_sum      (rsp_extent_sum),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   shape_stats_checker stats_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel           (req_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_set_count       (rsp_set_count),
      .rsp_perimeter_count (rsp_perimeter_count),
      .rsp_extent_sum      (rsp_extent_sum),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_pready          (csr_pready),
      .pending_results     (pending_results),
      .mismatch_count      (mismatch_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall results at random, or hold off for a long stretch when asked
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int unsigned used_dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // Mostly tiny sizes, sometimes zero or medium
   function automatic int unsigned pick_dim();
      case ($urandom_range(19))
         0:       return 0;
         1, 2:    return $urandom_range(24, 7);
         default: return $urandom_range(6, 1);
      endcase
   endfunction

   // Fill level of a frame: empty, full, dense with holes, or anything
   function automatic int pick_density();
      case ($urandom_range(9))
         0:       return 0;
         1:       return 100;
         2, 3:    return 90;
         default: return $urandom_range(100);
      endcase
   endfunction

   task automatic send_pixel(input logic p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame(input int density);
      repeat (frame_w * frame_h) send_pixel($urandom_range(99) < density);
      frames_done++;
   endtask

   // Hold the pixel channel until every predicted result has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CFG_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      wait_drained();
      csr_write(REG_WIDTH, CFG_W'(w));
      csr_write(REG_HEIGHT, CFG_W'(h));
      frame_w = used_dim(w, MAX_WIDTH);
      frame_h = used_dim(h, MAX_HEIGHT);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single pixel frames: empty and set
      set_geometry(1, 1);
      send_pixel(1'b0);
      send_pixel(1'b1);
      // full 3x3 block leaves one interior pixel
      set_geometry(3, 3);
      send_frame(100);
      // zero sizes act as one
      set_geometry(0, 0);
      send_pixel(1'b1);
      // abandon a frame midway, then a diagonal pair
      set_geometry(4, 2);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b0);
      set_geometry(2, 2);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b0);
      send_pixel(1'b1);

      // widest row, from an oversized width register value
      set_geometry(2047, 1);
      send_frame(90);

      // long result hold-off while small frames keep coming
      set_geometry(2, 2);
      send_idle_pct = 0;
      hold_asks <= hold_asks + 1;
      repeat (4) send_frame(pick_density());

      // random geometries and frames, idling pattern changing with progress
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS || frames_done < RANDOM_FRAMES) begin
         if (items_sent - random_start < RANDOM_ITEMS / 3) begin
            send_idle_pct = 6;
            recv_idle_pct <= 69;
         end else if (items_sent - random_start < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 69;
            recv_idle_pct <= 6;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         set_geometry(pick_dim(), pick_dim());
         repeat ($urandom_range(4, 1)) send_frame(pick_density());
         // now and then leave a frame unfinished before the next write
         if ($urandom_range(9) == 0 && frame_w * frame_h > 1) begin
            repeat ($urandom_range(frame_w * frame_h - 1, 1)) send_pixel(1'($urandom_range(1)));
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
